@@ rtl/sadv_pkg.sv @@
// Package with the shared constants, types and arithmetic helpers of the advection term block.
`default_nettype none

package sadv_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned TAP_W     = 3;
  localparam int unsigned VERT_TAPS = 5;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sd65536;

  // Register indexes on the configuration port (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_ALPHA = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VW0   = 3'd1;

  typedef enum logic [1:0] {
    CMD_NEIGHBOR = 2'd0,
    CMD_VERTICAL = 2'd1,
    CMD_FINISH   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ACC_DX,
    ACC_DY,
    ACC_DZ,
    ACC_DOT
  } acc_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NB_MX,
    ST_NB_MY,
    ST_NB_AY,
    ST_VT_MUL,
    ST_VT_ACC,
    ST_FN_HX,
    ST_FN_MX,
    ST_FN_GX,
    ST_FN_HY,
    ST_FN_MY,
    ST_FN_GY,
    ST_FN_GZ,
    ST_FN_PX,
    ST_FN_PY,
    ST_FN_PZ,
    ST_FN_AZ,
    ST_FN_D,
    ST_FN_MA,
    ST_FN_RES
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     clip;
  } rs_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] val;
    logic                    clip;
  } acc_t;

  // Drop 16 fraction bits rounding half up, then clip to the signed 32 bit range.
  function automatic rs_t round_sat(input logic signed [ACC_W-1:0] x);
    logic [48:0] r;
    rs_t         o;
    r = {x[63], x[63:16]} + {48'd0, x[15]};
    if (r[48:31] == {18{r[48]}}) begin
      o.val  = r[31:0];
      o.clip = 1'b0;
    end else begin
      o.val  = r[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      o.clip = 1'b1;
    end
    return o;
  endfunction

  // Signed 64 bit add that sticks at the range limits.
  function automatic acc_t sat_add(input logic signed [ACC_W-1:0] a,
                                   input logic signed [ACC_W-1:0] b);
    logic [ACC_W-1:0] s;
    acc_t             o;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      o.val  = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      o.clip = 1'b1;
    end else begin
      o.val  = s;
      o.clip = 1'b0;
    end
    return o;
  endfunction

  function automatic logic at_limit(input logic signed [ACC_W-1:0] x);
    return (x == {1'b0, {63{1'b1}}}) || (x == {1'b1, 63'd0});
  endfunction

endpackage

`default_nettype wire

@@ rtl/sadv_if.sv @@
// Valid/ready channel interfaces for the input words and the result words.
`default_nettype none

interface sadv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] sample_value;
  logic [31:0] weight_dx;
  logic [31:0] weight_dy;
  logic [31:0] radius_inverse;
  logic [31:0] velocity_x;
  logic [31:0] velocity_y;
  logic [31:0] velocity_z;

  modport source (output valid, command, sample_value, weight_dx, weight_dy,
                  radius_inverse, velocity_x, velocity_y, velocity_z,
                  input ready);
  modport sink (input valid, command, sample_value, weight_dx, weight_dy,
                radius_inverse, velocity_x, velocity_y, velocity_z,
                output ready);
endinterface

interface sadv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] advection_value;
  logic        saturated_flag;

  modport source (output valid, advection_value, saturated_flag, input ready);
  modport sink (input valid, advection_value, saturated_flag, output ready);
endinterface

`default_nettype wire

@@ rtl/stencil_advection_term.sv @@
// Top level of the advection term block: sequencer around one shared multiplier.
//
//   channel  | dir | handshake            | contents
//   ---------+-----+----------------------+-------------------------------------------
//   in_i     | in  | valid / ready        | command, sample, weights, 1/r, velocity
//   out_o    | out | valid / ready        | advection_value, saturated_flag
//   APB      | in  | psel/penable/pwrite  | scale_alpha, vert_weight_0..4 at 4*index
//
// A neighbor word runs the steps NB_MX, NB_MY and NB_AY before the next ready, a vertical word
// VT_MUL and VT_ACC (no step once all taps are in, or for an unknown command), a finish word
// FN_HX through FN_RES plus any wait for the result register to drain. The steps follow from
// the single 32x32 multiplier and the single round-and-clip unit, each used at most once per step.
// Reset is asynchronous and active low; it clears the sums, the tap counter and the
// registers to their documented values. The result sits in an output register, so
// new words are taken while an earlier result waits; only the final step stalls.
`default_nettype none

module stencil_advection_term #(
  parameter int unsigned VERT_TAPS = sadv_pkg::VERT_TAPS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  sadv_in_if.sink                          in_i,
  sadv_out_if.source                       out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sadv_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int unsigned DW = sadv_pkg::DATA_W;
  localparam int unsigned AW = sadv_pkg::ACC_W;
  localparam int unsigned TW = sadv_pkg::TAP_W;

  // Configuration registers.
  logic signed [DW-1:0] alpha_q;
  logic signed [DW-1:0] vw_q [VERT_TAPS];

  // Accumulated state.
  logic signed [AW-1:0] sum_dx_q, sum_dy_q, sum_dz_q;
  logic [TW-1:0]        tap_q;

  // Latched input word.
  logic signed [DW-1:0] sample_q, wdx_q, wdy_q, rinv_q, vx_q, vy_q, vz_q;

  // Working registers of the finish sequence.
  logic signed [AW-1:0] prod_q, dot_q;
  logic signed [DW-1:0] h_q, gx_q, gy_q, gz_q;
  logic                 flag_q;

  // Result register.
  logic                 out_valid_q;
  logic signed [DW-1:0] out_value_q;
  logic                 out_flag_q;

  sadv_pkg::state_e     state_q, state_d;

  // Datapath controls.
  logic                 mul_en;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] mul_p;
  sadv_pkg::acc_sel_e   acc_sel;
  logic signed [AW-1:0] acc_in;
  sadv_pkg::acc_t       acc_res;
  logic signed [AW-1:0] rs_in;
  sadv_pkg::rs_t        rs_res;
  logic signed [DW-1:0] vw_sel;
  logic                 out_load;
  logic                 in_fire;
  logic                 taps_left;

  logic [sadv_pkg::REG_IDX_W-1:0] cfg_idx;
  logic                           cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[sadv_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= sadv_pkg::ALPHA_RESET;
      for (int i = 0; i < VERT_TAPS; i++) begin
        vw_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      if (cfg_idx == sadv_pkg::REG_ALPHA) begin
        alpha_q <= pwdata;
      end
      for (int i = 0; i < VERT_TAPS; i++) begin
        if (cfg_idx == sadv_pkg::REG_VW0 + 3'(i)) begin
          vw_q[i] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == sadv_pkg::REG_ALPHA) begin
      prdata = alpha_q;
    end
    for (int i = 0; i < VERT_TAPS; i++) begin
      if (cfg_idx == sadv_pkg::REG_VW0 + 3'(i)) begin
        prdata = vw_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared arithmetic: one multiplier, one saturating accumulator adder and one
  // round-and-clip unit. The sequencer below steers their operands.
  // ---------------------------------------------------------------------------
  always_comb begin
    vw_sel = '0;
    for (int i = 0; i < VERT_TAPS; i++) begin
      if (tap_q == TW'(i)) begin
        vw_sel = vw_q[i];
      end
    end
  end

  assign taps_left = (tap_q < TW'(VERT_TAPS));
  assign mul_p     = mul_a * mul_b;

  always_comb begin
    unique case (acc_sel)
      sadv_pkg::ACC_DX:  acc_in = sum_dx_q;
      sadv_pkg::ACC_DY:  acc_in = sum_dy_q;
      sadv_pkg::ACC_DZ:  acc_in = sum_dz_q;
      sadv_pkg::ACC_DOT: acc_in = dot_q;
      default:           acc_in = sum_dx_q;
    endcase
  end

  assign acc_res = sadv_pkg::sat_add(acc_in, prod_q);
  assign rs_res  = sadv_pkg::round_sat(rs_in);

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sadv_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          case (sadv_pkg::cmd_e'(in_i.command))
            sadv_pkg::CMD_NEIGHBOR: state_d = sadv_pkg::ST_NB_MX;
            sadv_pkg::CMD_VERTICAL: state_d = taps_left ? sadv_pkg::ST_VT_MUL
                                                        : sadv_pkg::ST_IDLE;
            sadv_pkg::CMD_FINISH:   state_d = sadv_pkg::ST_FN_HX;
            default:                state_d = sadv_pkg::ST_IDLE;
          endcase
        end
      end
      sadv_pkg::ST_NB_MX:  state_d = sadv_pkg::ST_NB_MY;
      sadv_pkg::ST_NB_MY:  state_d = sadv_pkg::ST_NB_AY;
      sadv_pkg::ST_NB_AY:  state_d = sadv_pkg::ST_IDLE;
      sadv_pkg::ST_VT_MUL: state_d = sadv_pkg::ST_VT_ACC;
      sadv_pkg::ST_VT_ACC: state_d = sadv_pkg::ST_IDLE;
      sadv_pkg::ST_FN_HX:  state_d = sadv_pkg::ST_FN_MX;
      sadv_pkg::ST_FN_MX:  state_d = sadv_pkg::ST_FN_GX;
      sadv_pkg::ST_FN_GX:  state_d = sadv_pkg::ST_FN_HY;
      sadv_pkg::ST_FN_HY:  state_d = sadv_pkg::ST_FN_MY;
      sadv_pkg::ST_FN_MY:  state_d = sadv_pkg::ST_FN_GY;
      sadv_pkg::ST_FN_GY:  state_d = sadv_pkg::ST_FN_GZ;
      sadv_pkg::ST_FN_GZ:  state_d = sadv_pkg::ST_FN_PX;
      sadv_pkg::ST_FN_PX:  state_d = sadv_pkg::ST_FN_PY;
      sadv_pkg::ST_FN_PY:  state_d = sadv_pkg::ST_FN_PZ;
      sadv_pkg::ST_FN_PZ:  state_d = sadv_pkg::ST_FN_AZ;
      sadv_pkg::ST_FN_AZ:  state_d = sadv_pkg::ST_FN_D;
      sadv_pkg::ST_FN_D:   state_d = sadv_pkg::ST_FN_MA;
      sadv_pkg::ST_FN_MA:  state_d = sadv_pkg::ST_FN_RES;
      sadv_pkg::ST_FN_RES: state_d = out_load ? sadv_pkg::ST_IDLE : sadv_pkg::ST_FN_RES;
      default:             state_d = sadv_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: operand steering for each step. A product is written to prod_q
  // only in a multiply step, so it survives a stalled final step.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_i.ready = 1'b0;
    mul_en     = 1'b0;
    mul_a      = sample_q;
    mul_b      = wdx_q;
    acc_sel    = sadv_pkg::ACC_DX;
    rs_in      = prod_q;
    out_load   = 1'b0;
    unique case (state_q)
      sadv_pkg::ST_IDLE:   in_i.ready = 1'b1;
      sadv_pkg::ST_NB_MX:  mul_en = 1'b1;
      sadv_pkg::ST_NB_MY: begin
        mul_en  = 1'b1;
        mul_b   = wdy_q;
        acc_sel = sadv_pkg::ACC_DX;
      end
      sadv_pkg::ST_NB_AY:  acc_sel = sadv_pkg::ACC_DY;
      sadv_pkg::ST_VT_MUL: begin
        mul_en = 1'b1;
        mul_b  = vw_sel;
      end
      sadv_pkg::ST_VT_ACC: acc_sel = sadv_pkg::ACC_DZ;
      sadv_pkg::ST_FN_HX:  rs_in = sum_dx_q;
      sadv_pkg::ST_FN_MX, sadv_pkg::ST_FN_MY: begin
        mul_en = 1'b1;
        mul_a  = h_q;
        mul_b  = rinv_q;
      end
      sadv_pkg::ST_FN_GX, sadv_pkg::ST_FN_GY: rs_in = prod_q;
      sadv_pkg::ST_FN_HY:  rs_in = sum_dy_q;
      sadv_pkg::ST_FN_GZ:  rs_in = sum_dz_q;
      sadv_pkg::ST_FN_PX: begin
        mul_en = 1'b1;
        mul_a  = vx_q;
        mul_b  = gx_q;
      end
      sadv_pkg::ST_FN_PY: begin
        mul_en = 1'b1;
        mul_a  = vy_q;
        mul_b  = gy_q;
      end
      sadv_pkg::ST_FN_PZ: begin
        mul_en  = 1'b1;
        mul_a   = vz_q;
        mul_b   = gz_q;
        acc_sel = sadv_pkg::ACC_DOT;
      end
      sadv_pkg::ST_FN_AZ:  acc_sel = sadv_pkg::ACC_DOT;
      sadv_pkg::ST_FN_D:   rs_in = dot_q;
      sadv_pkg::ST_FN_MA: begin
        mul_en = 1'b1;
        mul_a  = alpha_q;
        mul_b  = h_q;
      end
      sadv_pkg::ST_FN_RES: begin
        rs_in    = prod_q;
        out_load = !out_valid_q || out_o.ready;
      end
      default: in_i.ready = 1'b0;
    endcase
  end

  assign in_fire = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sadv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Input word latch and working registers; no reset needed on payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_i.sample_value;
      wdx_q    <= in_i.weight_dx;
      wdy_q    <= in_i.weight_dy;
      rinv_q   <= in_i.radius_inverse;
      vx_q     <= in_i.velocity_x;
      vy_q     <= in_i.velocity_y;
      vz_q     <= in_i.velocity_z;
    end
    if (mul_en) begin
      prod_q <= mul_p;
    end
    case (state_q)
      sadv_pkg::ST_FN_HX: begin
        h_q    <= rs_res.val;
        // A sum stuck at a range limit counts as a clipped result.
        flag_q <= rs_res.clip || sadv_pkg::at_limit(sum_dx_q) ||
                  sadv_pkg::at_limit(sum_dy_q) || sadv_pkg::at_limit(sum_dz_q);
      end
      sadv_pkg::ST_FN_GX: begin
        gx_q   <= rs_res.val;
        flag_q <= flag_q || rs_res.clip;
      end
      sadv_pkg::ST_FN_HY, sadv_pkg::ST_FN_D: begin
        h_q    <= rs_res.val;
        flag_q <= flag_q || rs_res.clip;
      end
      sadv_pkg::ST_FN_GY: begin
        gy_q   <= rs_res.val;
        flag_q <= flag_q || rs_res.clip;
      end
      sadv_pkg::ST_FN_GZ: begin
        gz_q   <= rs_res.val;
        flag_q <= flag_q || rs_res.clip;
      end
      // The first product of the dot product cannot overflow 64 bits.
      sadv_pkg::ST_FN_PY: dot_q <= prod_q;
      sadv_pkg::ST_FN_PZ, sadv_pkg::ST_FN_AZ: begin
        dot_q  <= acc_res.val;
        flag_q <= flag_q || acc_res.clip;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_value_q <= rs_res.val;
      out_flag_q  <= flag_q || rs_res.clip;
    end
  end

  // Sums and tap counter. A finish clears them once its result is loaded into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_dx_q <= '0;
      sum_dy_q <= '0;
      sum_dz_q <= '0;
      tap_q    <= '0;
    end else if (out_load) begin
      sum_dx_q <= '0;
      sum_dy_q <= '0;
      sum_dz_q <= '0;
      tap_q    <= '0;
    end else begin
      if (state_q == sadv_pkg::ST_NB_MY) begin
        sum_dx_q <= acc_res.val;
      end
      if (state_q == sadv_pkg::ST_NB_AY) begin
        sum_dy_q <= acc_res.val;
      end
      if (state_q == sadv_pkg::ST_VT_ACC) begin
        sum_dz_q <= acc_res.val;
        tap_q    <= tap_q + TW'(1);
      end
    end
  end

  // Result register: valid holds until the sink takes the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.advection_value = out_value_q;
  assign out_o.saturated_flag  = out_flag_q;

endmodule

`default_nettype wire

@@ rtl/sadv_checker.sv @@
// Port-level checker for the advection term block, bound to its top level.
`default_nettype none

module sadv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic [1:0]  in_command_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_value_i,
  input wire logic        out_flag_i
);

  // Neighbor and finish words always occupy the sequencer for further cycles.
  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i &&
     (in_command_i == sadv_pkg::CMD_NEIGHBOR || in_command_i == sadv_pkg::CMD_FINISH))
    |=> !in_ready_i)
    else $error("input taken again right after a multi-cycle word");

  // A result appears only out of the final finish step, when the input side is closed.
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while the sequencer was idle");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result word dropped before it was taken");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_value_i) && $stable(out_flag_i)))
    else $error("stalled result word changed");

endmodule

bind stencil_advection_term sadv_checker u_sadv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_value_i  (out_o.advection_value),
  .out_flag_i   (out_o.saturated_flag)
);

`default_nettype wire
